// File: design/efd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the event frame decoder.
// No dependencies; every other file of the block imports this package.
package efd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned POS_W      = 17;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned CFG_IDX_W  = 8;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// header layout
	localparam int unsigned HDR_BYTES       = 11;
	localparam int unsigned FRAME_HDR_BYTES = 4;
	localparam int unsigned EVENT_HDR_BYTES = 7;

	localparam logic [3:0] OFS_VERSION  = 4'd0;
	localparam logic [3:0] OFS_TYPE     = 4'd1;
	localparam logic [3:0] OFS_OUTER_LO = 4'd2;
	localparam logic [3:0] OFS_OUTER_HI = 4'd3;
	localparam logic [3:0] OFS_TICK_B0  = 4'd4;
	localparam logic [3:0] OFS_TICK_B1  = 4'd5;
	localparam logic [3:0] OFS_TICK_B2  = 4'd6;
	localparam logic [3:0] OFS_TICK_B3  = 4'd7;
	localparam logic [3:0] OFS_EVENT    = 4'd8;
	localparam logic [3:0] OFS_INNER_LO = 4'd9;
	localparam logic [3:0] OFS_INNER_HI = 4'd10;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_WIRE_VERSION   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EVENT_MSG_CODE = 8'd1;
	localparam logic [BYTE_W-1:0]    WIRE_VERSION_RST   = 8'd1;
	localparam logic [BYTE_W-1:0]    EVENT_MSG_CODE_RST = 8'd0;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_SHORT       = 3'd1,
		STAT_BAD_VERSION = 3'd2,
		STAT_BAD_TYPE    = 3'd3,
		STAT_FRAME_LEN   = 3'd4,
		STAT_EVENT_LEN   = 3'd5
	} efd_status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} efd_kind_t;

	// one queue entry: up to one payload word and one status word
	typedef struct packed {
		logic              has_payload;
		logic [BYTE_W-1:0] payload;
		logic              has_status;
		efd_status_t       status;
		logic [TICK_W-1:0] tick;
		logic [BYTE_W-1:0] event_code;
		logic [SIZE_W-1:0] event_length;
	} efd_cmd_t;

endpackage

// File: design/efd_intf.sv
`timescale 1ns / 1ps
// Handshake channels of the event frame decoder: byte input, result output
// and configuration write. Depends on efd_pkg.
interface efd_in_if import efd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              frame_end;

	modport source (output valid, in_byte, frame_end, input ready);
	modport sink (input valid, in_byte, frame_end, output ready);
endinterface

interface efd_out_if import efd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                item_kind;
	logic [BYTE_W-1:0]   payload_byte;
	logic [STATUS_W-1:0] status_code;
	logic [TICK_W-1:0]   tick_number;
	logic [BYTE_W-1:0]   event_code;
	logic [SIZE_W-1:0]   event_length;
	logic                run_last;

	modport source (output valid, item_kind, payload_byte, status_code, tick_number,
		event_code, event_length, run_last, input ready);
	modport sink (input valid, item_kind, payload_byte, status_code, tick_number,
		event_code, event_length, run_last, output ready);
endinterface

interface efd_cfg_if import efd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/efd_front.sv
`timescale 1ns / 1ps
// Front end: accepts frame bytes, collects the header fields, checks the
// frame at its end and pushes commands to the queue. Depends on efd_pkg.
module efd_front import efd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	efd_in_if.sink    bytes,
	efd_cfg_if.sink   cfg,
	input  logic      q_full,
	output logic      push,
	output efd_cmd_t  cmd
);

	logic [BYTE_W-1:0] wire_version_q;
	logic [BYTE_W-1:0] event_msg_code_q;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] version_q, type_q, event_q;
	logic [SIZE_W-1:0] outer_q, inner_q;
	logic [TICK_W-1:0] tick_q;

	logic [POS_W-1:0]  pos_n;
	logic [BYTE_W-1:0] version_n, type_n, event_n;
	logic [SIZE_W-1:0] outer_n, inner_n;
	logic [TICK_W-1:0] tick_n;
	logic              in_hdr;
	logic              accept;
	efd_status_t       status;

	assign cfg.ready   = 1'b1;
	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;
	assign in_hdr      = pos_q < POS_W'(HDR_BYTES);
	assign pos_n       = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	always_comb begin
		version_n = version_q;
		type_n    = type_q;
		outer_n   = outer_q;
		tick_n    = tick_q;
		event_n   = event_q;
		inner_n   = inner_q;
		if (in_hdr) begin
			case (pos_q[3:0])
				OFS_VERSION:  version_n      = bytes.in_byte;
				OFS_TYPE:     type_n         = bytes.in_byte;
				OFS_OUTER_LO: outer_n[7:0]   = bytes.in_byte;
				OFS_OUTER_HI: outer_n[15:8]  = bytes.in_byte;
				OFS_TICK_B0:  tick_n[7:0]    = bytes.in_byte;
				OFS_TICK_B1:  tick_n[15:8]   = bytes.in_byte;
				OFS_TICK_B2:  tick_n[23:16]  = bytes.in_byte;
				OFS_TICK_B3:  tick_n[31:24]  = bytes.in_byte;
				OFS_EVENT:    event_n        = bytes.in_byte;
				OFS_INNER_LO: inner_n[7:0]   = bytes.in_byte;
				OFS_INNER_HI: inner_n[15:8]  = bytes.in_byte;
				default: ;
			endcase
		end
	end

	// first failing check wins; length counts the current byte
	always_comb begin
		if (pos_n < POS_W'(HDR_BYTES))
			status = STAT_SHORT;
		else if (version_n != wire_version_q)
			status = STAT_BAD_VERSION;
		else if (type_n != event_msg_code_q)
			status = STAT_BAD_TYPE;
		else if (pos_n != POS_W'(FRAME_HDR_BYTES) + POS_W'(outer_n))
			status = STAT_FRAME_LEN;
		else if (POS_W'(outer_n) != POS_W'(EVENT_HDR_BYTES) + POS_W'(inner_n))
			status = STAT_EVENT_LEN;
		else
			status = STAT_OK;
	end

	always_comb begin
		cmd.has_payload  = !in_hdr;
		cmd.payload      = bytes.in_byte;
		cmd.has_status   = bytes.frame_end;
		cmd.status       = status;
		cmd.tick         = tick_n;
		cmd.event_code   = event_n;
		cmd.event_length = inner_n;
	end

	assign push = accept && (!in_hdr || bytes.frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_version_q   <= WIRE_VERSION_RST;
			event_msg_code_q <= EVENT_MSG_CODE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_WIRE_VERSION:   wire_version_q   <= cfg.data;
				CFG_EVENT_MSG_CODE: event_msg_code_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			version_q <= '0;
			type_q    <= '0;
			outer_q   <= '0;
			tick_q    <= '0;
			event_q   <= '0;
			inner_q   <= '0;
		end else if (accept) begin
			if (bytes.frame_end) begin
				// start the next frame clean
				pos_q     <= '0;
				version_q <= '0;
				type_q    <= '0;
				outer_q   <= '0;
				tick_q    <= '0;
				event_q   <= '0;
				inner_q   <= '0;
			end else begin
				pos_q     <= pos_n;
				version_q <= version_n;
				type_q    <= type_n;
				outer_q   <= outer_n;
				tick_q    <= tick_n;
				event_q   <= event_n;
				inner_q   <= inner_n;
			end
		end
	end

endmodule

// File: design/efd_queue.sv
`timescale 1ns / 1ps
// Command queue between the front end and the back end.
// Depends on efd_pkg for the command type.
module efd_queue import efd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  efd_cmd_t push_cmd,
	output logic     full,
	output logic     head_valid,
	output efd_cmd_t head,
	input  logic     pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	efd_cmd_t          slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: design/efd_back.sv
`timescale 1ns / 1ps
// Back end: turns each queued command into one or two result words
// (payload first, then status) through an output register. Depends on efd_pkg.
module efd_back import efd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  efd_cmd_t  head,
	output logic      pop,
	efd_out_if.source results
);

	logic                out_valid_q;
	efd_kind_t           kind_q;
	logic [BYTE_W-1:0]   payload_q;
	logic [STATUS_W-1:0] status_q;
	logic [TICK_W-1:0]   tick_q;
	logic [BYTE_W-1:0]   event_q;
	logic [SIZE_W-1:0]   length_q;
	logic                payload_done_q;

	logic load;
	logic send_payload;

	assign load         = head_valid && (!out_valid_q || results.ready);
	assign send_payload = head.has_payload && !payload_done_q;
	// hold the head while its status word is still to come
	assign pop          = load && (!send_payload || !head.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			payload_done_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			if (load)
				payload_done_q <= send_payload && head.has_status;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_payload) begin
				kind_q    <= KIND_PAYLOAD;
				payload_q <= head.payload;
				status_q  <= '0;
				tick_q    <= '0;
				event_q   <= '0;
				length_q  <= '0;
			end else begin
				kind_q    <= KIND_STATUS;
				payload_q <= '0;
				status_q  <= head.status;
				tick_q    <= head.tick;
				event_q   <= head.event_code;
				length_q  <= head.event_length;
			end
		end
	end

	assign results.valid        = out_valid_q;
	assign results.item_kind    = kind_q;
	assign results.payload_byte = payload_q;
	assign results.status_code  = status_q;
	assign results.tick_number  = tick_q;
	assign results.event_code   = event_q;
	assign results.event_length = length_q;
	assign results.run_last     = kind_q == KIND_STATUS;

endmodule

// File: design/event_frame_decoder.sv
`timescale 1ns / 1ps
// Event frame decoder: takes one frame byte per cycle on bytes, decodes the
// 11-byte header (version, message type, outer size, tick, event type, event
// length) and forwards every later byte as a payload word; the byte flagged
// frame_end is followed by one status word carrying the check result and the
// decoded tick, event type and event length. A byte is taken every cycle while
// the command queue (QUEUE_DEPTH entries) has room; the result port moves one
// word per cycle while results.ready is high, so a frame-end byte that also
// carries payload gives the back end two words, which the queue absorbs.
// Configuration writes take effect at once and are meant for idle time.
// Depends on efd_pkg and the channel interfaces.
module event_frame_decoder import efd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	efd_in_if.sink    bytes,
	efd_out_if.source results,
	efd_cfg_if.sink   cfg
);

	logic     q_full;
	logic     push;
	efd_cmd_t push_cmd;
	logic     head_valid;
	efd_cmd_t head;
	logic     pop;

	efd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	efd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	efd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

	a_status_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.item_kind) |->
		(results.run_last && results.payload_byte == '0))
		else $error("status word with payload or without run_last");

	a_payload_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.item_kind) |->
		(!results.run_last && results.status_code == '0 && results.tick_number == '0))
		else $error("payload word carries status fields");

endmodule

// File: bench/efd_checker.sv
`timescale 1ns / 1ps
// Watches the byte, result and configuration channels of the event frame decoder,
// predicts every result word from the accepted bytes and compares them in order.
// Depends on efd_pkg and the channel interfaces.
module efd_checker import efd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	efd_in_if            bytes_mon,
	efd_out_if           results_mon,
	efd_cfg_if           cfg_mon,
	output int unsigned  mismatches,
	output int unsigned  outstanding,
	output int unsigned  words_checked,
	output int unsigned  frames_ok,
	output int unsigned  frames_rejected,
	output logic [5:0]   codes_seen
);

	typedef struct packed {
		efd_kind_t         kind;
		logic [BYTE_W-1:0] payload;
		efd_status_t       status;
		logic [TICK_W-1:0] tick;
		logic [BYTE_W-1:0] evt;
		logic [SIZE_W-1:0] len;
		logic              last;
	} dec_word_t;

	logic [BYTE_W-1:0] wire_ver;
	logic [BYTE_W-1:0] msg_code;

	logic [POS_W-1:0]  at_pos;
	logic [BYTE_W-1:0] got_ver;
	logic [BYTE_W-1:0] got_type;
	logic [SIZE_W-1:0] got_outer;
	logic [TICK_W-1:0] got_tick;
	logic [BYTE_W-1:0] got_event;
	logic [SIZE_W-1:0] got_inner;

	dec_word_t decoded_q[$];

	task automatic clear_frame();
		at_pos    = '0;
		got_ver   = '0;
		got_type  = '0;
		got_outer = '0;
		got_tick  = '0;
		got_event = '0;
		got_inner = '0;
	endtask

	// first failing check wins
	function automatic efd_status_t frame_verdict(input logic [POS_W-1:0] len);
		int unsigned frame_len;
		int unsigned outer;
		int unsigned inner;
		frame_len = 32'(len);
		outer = 32'(got_outer);
		inner = 32'(got_inner);
		if (frame_len < HDR_BYTES) return STAT_SHORT;
		if (got_ver != wire_ver) return STAT_BAD_VERSION;
		if (got_type != msg_code) return STAT_BAD_TYPE;
		if (frame_len != FRAME_HDR_BYTES + outer) return STAT_FRAME_LEN;
		if (outer != EVENT_HDR_BYTES + inner) return STAT_EVENT_LEN;
		return STAT_OK;
	endfunction

	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
		dec_word_t w;
		if (at_pos < HDR_BYTES) begin
			case (at_pos[3:0])
				OFS_VERSION:  got_ver = b;
				OFS_TYPE:     got_type = b;
				OFS_OUTER_LO: got_outer[7:0] = b;
				OFS_OUTER_HI: got_outer[15:8] = b;
				OFS_TICK_B0:  got_tick[7:0] = b;
				OFS_TICK_B1:  got_tick[15:8] = b;
				OFS_TICK_B2:  got_tick[23:16] = b;
				OFS_TICK_B3:  got_tick[31:24] = b;
				OFS_EVENT:    got_event = b;
				OFS_INNER_LO: got_inner[7:0] = b;
				OFS_INNER_HI: got_inner[15:8] = b;
				default: ;
			endcase
		end else begin
			w = '0;
			w.kind = KIND_PAYLOAD;
			w.payload = b;
			decoded_q.push_back(w);
		end
		// saturate the position
		if (at_pos != POS_MAX)
			at_pos = at_pos + 1'b1;
		if (last) begin
			w = '0;
			w.kind = KIND_STATUS;
			w.status = frame_verdict(at_pos);
			w.tick = got_tick;
			w.evt = got_event;
			w.len = got_inner;
			w.last = 1'b1;
			decoded_q.push_back(w);
			codes_seen[w.status] = 1'b1;
			if (w.status == STAT_OK)
				frames_ok++;
			else
				frames_rejected++;
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		dec_word_t head;
		if (!arst_n) begin
			wire_ver = WIRE_VERSION_RST;
			msg_code = EVENT_MSG_CODE_RST;
			clear_frame();
			decoded_q.delete();
			mismatches = 0;
			outstanding = 0;
			words_checked = 0;
			frames_ok = 0;
			frames_rejected = 0;
			codes_seen = '0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					CFG_WIRE_VERSION:   wire_ver = cfg_mon.data;
					CFG_EVENT_MSG_CODE: msg_code = cfg_mon.data;
					default: ;
				endcase
			end
			if (bytes_mon.valid && bytes_mon.ready)
				decode_byte(bytes_mon.in_byte, bytes_mon.frame_end);
			if (results_mon.valid && results_mon.ready) begin
				if (decoded_q.size() == 0) begin
					mismatches++;
					$display({"%0t: result word with nothing expected, expected none, ",
						"got kind %0d payload %0h status %0d"},
						$time, results_mon.item_kind, results_mon.payload_byte,
						results_mon.status_code);
				end else begin
					head = decoded_q.pop_front();
					check_field("item_kind", 32'(head.kind), 32'(results_mon.item_kind));
					check_field("payload_byte", 32'(head.payload),
						32'(results_mon.payload_byte));
					check_field("status_code", 32'(head.status),
						32'(results_mon.status_code));
					check_field("tick_number", head.tick, results_mon.tick_number);
					check_field("event_code", 32'(head.evt), 32'(results_mon.event_code));
					check_field("event_length", 32'(head.len),
						32'(results_mon.event_length));
					check_field("run_last", 32'(head.last), 32'(results_mon.run_last));
					words_checked++;
				end
			end
			outstanding = decoded_q.size();
		end
	end

endmodule

// File: bench/tb_event_frame_decoder.sv
`timescale 1ns / 1ps
// Testbench top of the event frame decoder: clock, reset, frame stimulus,
// configuration phases, result back-pressure and the verdict.
// Depends on efd_pkg, the channel interfaces, efd_checker and the block itself.
module tb_event_frame_decoder;
	import efd_pkg::*;

	localparam int unsigned IDLE_LIMIT       = 4000;
	localparam int unsigned DRAIN_CYCLES     = 4;
	localparam int unsigned PHASE_BYTES      = 280;
	localparam int unsigned RANDOM_PHASES    = 4;
	localparam int          FILL_RANDOM      = -1;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_EVENT_MSG_CODE + 1'b1;

	typedef enum {
		FR_GOOD,
		FR_SHORT,
		FR_BAD_VERSION,
		FR_BAD_TYPE,
		FR_BAD_OUTER,
		FR_BAD_INNER,
		FR_NOISE
	} frame_shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	efd_in_if  bytes_ch ();
	efd_out_if res_ch ();
	efd_cfg_if cfg_ch ();

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned words_checked;
	int unsigned frames_ok;
	int unsigned frames_rejected;
	logic [5:0]  codes_seen;

	logic [BYTE_W-1:0] frame_q[$];
	logic [BYTE_W-1:0] cur_version = WIRE_VERSION_RST;
	logic [BYTE_W-1:0] cur_type = EVENT_MSG_CODE_RST;
	bit                burst = 1'b0;
	int unsigned       sent_bytes = 0;
	int unsigned       quiet = 0;

	always #1 clk = ~clk;

	event_frame_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	efd_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.bytes_mon       (bytes_ch),
		.results_mon     (res_ch),
		.cfg_mon         (cfg_ch),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.words_checked   (words_checked),
		.frames_ok       (frames_ok),
		.frames_rejected (frames_rejected),
		.codes_seen      (codes_seen)
	);

	function automatic int unsigned pause_len();
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic trim_frame(input int unsigned keep);
		while (frame_q.size() > keep)
			void'(frame_q.pop_back());
	endtask

	task automatic build_frame(input frame_shape_t shape, input int unsigned inner_len,
		input logic [TICK_W-1:0] tick, input logic [BYTE_W-1:0] evt, input int fill);
		logic [BYTE_W-1:0] ver;
		logic [BYTE_W-1:0] typ;
		logic [SIZE_W-1:0] outer;
		logic [SIZE_W-1:0] inner;
		int body;
		int d;
		frame_q.delete();
		ver = cur_version;
		typ = cur_type;
		inner = SIZE_W'(inner_len);
		body = inner_len;
		d = $urandom_range(1, 3);
		if ($urandom_range(0, 1))
			d = -d;
		if (body + d < 0)
			d = -d;
		case (shape)
			FR_BAD_VERSION: ver = ver ^ BYTE_W'($urandom_range(1, 255));
			FR_BAD_TYPE:    typ = typ ^ BYTE_W'($urandom_range(1, 255));
			FR_BAD_OUTER, FR_BAD_INNER: body = body + d;
			default: ;
		endcase
		// a bad event length keeps the frame length consistent with the outer size
		outer = SIZE_W'(EVENT_HDR_BYTES + ((shape == FR_BAD_INNER) ? body : inner_len));
		if (shape == FR_NOISE) begin
			repeat ($urandom_range(1, 30))
				frame_q.push_back(BYTE_W'($urandom_range(0, 255)));
		end else begin
			frame_q.push_back(ver);
			frame_q.push_back(typ);
			frame_q.push_back(outer[7:0]);
			frame_q.push_back(outer[15:8]);
			frame_q.push_back(tick[7:0]);
			frame_q.push_back(tick[15:8]);
			frame_q.push_back(tick[23:16]);
			frame_q.push_back(tick[31:24]);
			frame_q.push_back(evt);
			frame_q.push_back(inner[7:0]);
			frame_q.push_back(inner[15:8]);
			repeat (body)
				frame_q.push_back((fill < 0) ? BYTE_W'($urandom_range(0, 255)) :
					BYTE_W'(fill));
			if (shape == FR_SHORT)
				trim_frame($urandom_range(1, HDR_BYTES - 1));
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int unsigned gap;
		gap = pause_len();
		if (gap > 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.in_byte <= b;
		bytes_ch.frame_end <= last;
		do @(posedge clk); while (!(bytes_ch.valid && bytes_ch.ready));
		@(negedge clk);
		sent_bytes++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic random_frame();
		int unsigned pick;
		int unsigned inner_len;
		frame_shape_t shape;
		pick = $urandom_range(0, 99);
		if (pick < 55) shape = FR_GOOD;
		else if (pick < 62) shape = FR_SHORT;
		else if (pick < 68) shape = FR_BAD_VERSION;
		else if (pick < 74) shape = FR_BAD_TYPE;
		else if (pick < 82) shape = FR_BAD_OUTER;
		else if (pick < 90) shape = FR_BAD_INNER;
		else shape = FR_NOISE;
		inner_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200) :
			$urandom_range(0, 24);
		burst = ($urandom_range(0, 4) == 0);
		build_frame(shape, inner_len, $urandom, BYTE_W'($urandom_range(0, 255)),
			FILL_RANDOM);
		send_frame();
	endtask

	// drop the byte valid and let the block drain
	task automatic settle();
		bytes_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		case (idx)
			CFG_WIRE_VERSION:   cur_version = val;
			CFG_EVENT_MSG_CODE: cur_type = val;
			default: ;
		endcase
	endtask

	task automatic reconfigure(input logic [BYTE_W-1:0] ver, input logic [BYTE_W-1:0] typ);
		settle();
		write_reg(CFG_WIRE_VERSION, ver);
		write_reg(CFG_EVENT_MSG_CODE, typ);
		// unmapped index, must be ignored
		write_reg(CFG_IDX_W'($urandom_range(CFG_NO_REG, 255)),
			BYTE_W'($urandom_range(0, 255)));
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: random stall before each word
	initial begin : sink
		int unsigned stall;
		res_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = pause_len();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((bytes_ch.valid && bytes_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("event_frame_decoder: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned phase_start;
		bytes_ch.valid = 1'b0;
		bytes_ch.in_byte = '0;
		bytes_ch.frame_end = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames under the reset configuration
		build_frame(FR_GOOD, 0, '0, '0, 0);
		send_frame();
		build_frame(FR_GOOD, 3, '1, '1, 255);
		send_frame();
		build_frame(FR_GOOD, 5, $urandom, BYTE_W'($urandom_range(0, 255)), 0);
		send_frame();
		build_frame(FR_GOOD, 4, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		trim_frame(1);
		send_frame();
		build_frame(FR_GOOD, 4, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		trim_frame(HDR_BYTES - 1);
		send_frame();
		build_frame(FR_BAD_VERSION, 2, $urandom, BYTE_W'($urandom_range(0, 255)),
			FILL_RANDOM);
		send_frame();
		build_frame(FR_BAD_TYPE, 2, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		send_frame();
		build_frame(FR_BAD_OUTER, 3, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		send_frame();
		build_frame(FR_BAD_INNER, 3, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		send_frame();

		reconfigure(8'hFF, 8'hFF);
		build_frame(FR_GOOD, 2, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		send_frame();
		build_frame(FR_BAD_TYPE, 1, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		send_frame();
		reconfigure(8'h00, 8'h00);
		build_frame(FR_GOOD, 2, $urandom, BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
		send_frame();
		build_frame(FR_NOISE, 0, '0, '0, FILL_RANDOM);
		send_frame();

		// random frames, one configuration per phase
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: reconfigure(BYTE_W'($urandom_range(0, 255)),
					BYTE_W'($urandom_range(0, 255)));
				1: reconfigure(8'h00, 8'hFF);
				2: reconfigure(8'hFF, 8'h00);
				default: reconfigure(WIRE_VERSION_RST, EVENT_MSG_CODE_RST);
			endcase
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_BYTES)
				random_frame();
		end
		burst = 1'b0;

		settle();
		repeat (2 * DRAIN_CYCLES) @(negedge clk);
		$display("Run covered %0d bytes in, %0d result words checked,",
			sent_bytes, words_checked);
		$display("%0d frames ok, %0d rejected; status codes seen, one bit per code: %b",
			frames_ok, frames_rejected, codes_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("event_frame_decoder: match");
		else
			$display("event_frame_decoder: mismatch");
		$finish;
	end

endmodule
